// ===== hw/rtl/dsrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Diffusion stencil row builder package
// Shared word types, register indexes, row kinds, default parameters and the pipeline depth constant.
// ----------------------------------------------------------------------------
package dsrb_pkg;

  localparam int INDEX_BITS_DEFAULT      = 12;
  localparam int POW_TABLE_DEPTH_DEFAULT = 256;

  // Depth of the face conductivity pipeline in register stages.
  localparam int COND_STAGES = 8;

  typedef enum logic [2:0] {
    REG_SOLVE_MODE     = 3'd0,
    REG_COND_SCALE     = 3'd1,
    REG_COND_EXPONENT  = 3'd2,
    REG_RADIATION      = 3'd3,
    REG_SOURCE         = 3'd4,
    REG_SOURCE_END     = 3'd5,
    REG_INV_SPACING_SQ = 3'd6,
    REG_TIME_STEP      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_INTERIOR = 2'd0,
    KIND_MIRROR   = 2'd1,
    KIND_FIXED    = 2'd2
  } row_kind_e;

  typedef struct packed {
    logic [11:0]        point_index;
    logic               is_last_point;
    logic signed [31:0] left_value;
    logic signed [31:0] center_value;
    logic signed [31:0] right_value;
  } point_word_t;

  typedef struct packed {
    logic [11:0]        row_number;
    row_kind_e          row_kind;
    logic signed [31:0] lower_coef;
    logic signed [31:0] diag_coef;
    logic signed [31:0] upper_coef;
    logic signed [31:0] rhs_value;
    logic               saturated;
  } row_word_t;

  // Face conductivity and whether it was clamped.
  typedef struct packed {
    logic [30:0] k;
    logic        sat;
  } cond_t;

endpackage

// ===== hw/rtl/dsrb_conduct.sv =====
// ----------------------------------------------------------------------------
// Face conductivity pipeline
// Computes k0*m^q for the floor mean m of two values via log2 and exp2 tables.
// ----------------------------------------------------------------------------
module dsrb_conduct #(
  parameter int POW_TABLE_DEPTH = dsrb_pkg::POW_TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic [dsrb_pkg::COND_STAGES-1:0]    en,
  input  logic signed [31:0]                  a,
  input  logic signed [31:0]                  b,
  input  logic [30:0]                         k0,
  input  logic [19:0]                         q,
  output dsrb_pkg::cond_t                     res
);
  import dsrb_pkg::*;

  localparam int JB = $clog2(POW_TABLE_DEPTH);

  typedef logic [15:0] log_tab_t [POW_TABLE_DEPTH];
  typedef logic [30:0] exp_tab_t [POW_TABLE_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bt;
    n  = n_in;
    r  = '0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic log_tab_t build_log();
    log_tab_t    t;
    logic [63:0] x;
    logic [15:0] r;
    for (int j = 0; j < POW_TABLE_DEPTH; j++) begin
      x = ((64'(POW_TABLE_DEPTH) + 64'(j)) << 30) / 64'(POW_TABLE_DEPTH);
      r = '0;
      for (int bi = 15; bi >= 0; bi--) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x     = x >> 1;
          r[bi] = 1'b1;
        end
      end
      t[j] = r;
    end
    return t;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t    t;
    logic [63:0] f16;
    logic [63:0] y;
    logic [63:0] root;
    for (int j = 0; j < POW_TABLE_DEPTH; j++) begin
      f16  = (64'(j) << 16) / 64'(POW_TABLE_DEPTH);
      y    = 64'd1 << 30;
      root = isqrt64(64'd1 << 61);
      for (int n = 0; n < 16; n++) begin
        if (f16[15-n]) y = (y * root) >> 30;
        root = isqrt64(root << 30);
      end
      t[j] = y[30:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log();
  localparam exp_tab_t EXP_TAB = build_exp();

  // Stage registers.
  logic [30:0]        c1_m;
  logic               c1_pos;
  logic [4:0]         c2_p;
  logic [30:0]        c2_rem;
  logic               c2_pos;
  logic [JB-1:0]      c3_j;
  logic [4:0]         c3_p;
  logic               c3_pos;
  logic [15:0]        c4_lf;
  logic [4:0]         c4_p;
  logic               c4_pos;
  logic signed [26:0] c5_e;
  logic               c5_pos;
  logic [30:0]        c6_y;
  logic signed [10:0] c6_ip;
  logic               c6_pos;
  logic [61:0]        c7_prod;
  logic signed [10:0] c7_ip;
  logic               c7_pos;
  cond_t              c8;

  logic signed [32:0] sum_ab;
  logic [4:0]         lead;
  logic [5:0]         pm16;
  logic signed [21:0] lval;
  logic signed [42:0] lq;
  logic [JB-1:0]      jj;
  logic signed [11:0] sh;
  logic [11:0]        nsh;
  logic [61:0]        rsh;
  logic [61:0]        chk;
  cond_t              k_next;

  assign sum_ab = 33'(a) + 33'(b);

  always_comb begin
    lead = '0;
    for (int i = 0; i < 31; i++) begin
      if (c1_m[i]) lead = 5'(i);
    end
  end

  assign pm16 = {1'b0, c4_p} - 6'd16;
  assign lval = $signed({pm16, c4_lf});
  assign lq   = 43'(lval) * 43'($signed({1'b0, q}));
  assign jj   = JB'((32'(c5_e[15:0]) * 32'(POW_TABLE_DEPTH)) >> 16);
  assign sh   = 12'(c7_ip) - 12'sd30;
  assign nsh  = 12'(-sh);
  assign rsh  = c7_prod >> nsh[5:0];
  assign chk  = c7_prod >> (5'd31 - sh[4:0]);

  always_comb begin
    k_next = '0;
    if (c7_pos && (c7_prod != '0)) begin
      if (!sh[11]) begin
        if ((sh > 12'sd31) || (chk != '0)) begin
          k_next.k   = 31'h7FFF_FFFF;
          k_next.sat = 1'b1;
        end else begin
          k_next.k = 31'(c7_prod << sh[4:0]);
        end
      end else if (nsh < 12'd64) begin
        if (rsh[61:31] != '0) begin
          k_next.k   = 31'h7FFF_FFFF;
          k_next.sat = 1'b1;
        end else begin
          k_next.k = rsh[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c1_m   <= sum_ab[31:1];
      c1_pos <= !sum_ab[32] && (sum_ab[32:1] != '0);
    end
    if (en[1]) begin
      c2_p   <= lead;
      c2_rem <= c1_m & ~(31'd1 << lead);
      c2_pos <= c1_pos;
    end
    if (en[2]) begin
      c3_j   <= JB'((64'(c2_rem) * 64'(POW_TABLE_DEPTH)) >> c2_p);
      c3_p   <= c2_p;
      c3_pos <= c2_pos;
    end
    if (en[3]) begin
      c4_lf  <= LOG_TAB[c3_j];
      c4_p   <= c3_p;
      c4_pos <= c3_pos;
    end
    if (en[4]) begin
      c5_e   <= 27'(lq >>> 16);
      c5_pos <= c4_pos;
    end
    if (en[5]) begin
      c6_y   <= EXP_TAB[jj];
      c6_ip  <= c5_e[26:16];
      c6_pos <= c5_pos;
    end
    if (en[6]) begin
      c7_prod <= 62'(k0) * 62'(c6_y);
      c7_ip   <= c6_ip;
      c7_pos  <= c6_pos;
    end
    if (en[7]) begin
      c8 <= k_next;
    end
  end

  assign res = c8;

endmodule

// ===== hw/rtl/diffusion_stencil_row_builder_core.sv =====
// ----------------------------------------------------------------------------
// Diffusion stencil row builder
// Builds one tridiagonal row and right-hand side per grid point word.
// ----------------------------------------------------------------------------
// Point words arrive on the point channel (point_valid, point_stall, point) and
// each yields exactly one row word on the row channel (row_valid, row_stall,
// row). A word moves at a rising edge where valid is high and stall is low.
// The datapath is a twelve stage pipeline that takes one point word per cycle
// while point_stall is low. Its depth is set by the face conductivity
// path, which runs a log table lookup, the
// exponent multiply, an exp table lookup and the scaling multiply in series,
// followed by the conductance, time step and flux multiplies.
// Each stage holds its word until the next stage is free, so bubbles close
// up while the receiver stalls and point_stall only rises once the pipeline
// is full behind a stalled row word. Nothing is lost or repeated.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data and must only be changed while the pipeline is empty.
// Synchronous reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module diffusion_stencil_row_builder_core #(
  parameter int INDEX_BITS      = dsrb_pkg::INDEX_BITS_DEFAULT,
  parameter int POW_TABLE_DEPTH = dsrb_pkg::POW_TABLE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  dsrb_pkg::point_word_t point,
  output logic                  row_valid,
  input  logic                  row_stall,
  output dsrb_pkg::row_word_t   row,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [30:0]           cfg_data
);
  import dsrb_pkg::*;

  localparam int NS = 12;          // total pipeline stages, the last holds the row word
  localparam int MS = NS - 1;      // stages that carry the side data
  localparam int IB = (INDEX_BITS < 12) ? INDEX_BITS : 12;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;

  // Saturation flags collected along the way; the branch decides which count.
  typedef struct packed {
    logic uu, cube, rad, dr, dl, ssrc, cu, r1, res, kl, kr, gl, gr, sum, flux;
  } flag_t;

  typedef struct packed {
    logic [11:0]        row;
    logic               last;
    logic               mirror;
    logic               src_on;
    logic signed [31:0] u;
    logic signed [31:0] d_r;
    logic signed [31:0] d_l;
    logic [30:0]        ssrc;
    logic signed [31:0] rad;
    logic signed [31:0] r1;
    logic signed [31:0] res;
    logic signed [31:0] sum;
    logic signed [31:0] flux;
    logic [30:0]        gl;
    logic [30:0]        gr;
    flag_t              fl;
  } meta_t;

  // Clamp to the Q16.16 range; the top bit reports a clamp.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < 64'shFFFF_FFFF_8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // Configuration registers.
  logic        solve_mode;
  logic [30:0] conductivity_scale;
  logic [19:0] conductivity_exponent;
  logic [30:0] radiation_constant;
  logic [30:0] source_strength;
  logic [11:0] source_end_index;
  logic [24:0] inverse_spacing_squared;
  logic [30:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      solve_mode              <= 1'b0;
      conductivity_scale      <= 31'd655;
      conductivity_exponent   <= 20'd32768;
      radiation_constant      <= 31'd6554;
      source_strength         <= 31'd65536;
      source_end_index        <= 12'd10;
      inverse_spacing_squared <= 25'd2500;
      time_step               <= 31'd6554;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SOLVE_MODE:     solve_mode              <= cfg_data[0];
        REG_COND_SCALE:     conductivity_scale      <= cfg_data;
        REG_COND_EXPONENT:  conductivity_exponent   <= cfg_data[19:0];
        REG_RADIATION:      radiation_constant      <= cfg_data;
        REG_SOURCE:         source_strength         <= cfg_data;
        REG_SOURCE_END:     source_end_index        <= cfg_data[11:0];
        REG_INV_SPACING_SQ: inverse_spacing_squared <= cfg_data[24:0];
        REG_TIME_STEP:      time_step               <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [31:0] sig_s;
  logic signed [31:0] dt_s;
  logic signed [25:0] spc_s;
  assign sig_s = $signed({1'b0, radiation_constant});
  assign dt_s  = $signed({1'b0, time_step});
  assign spc_s = $signed({1'b0, inverse_spacing_squared});

  // Stage handshake. A stage loads when it is empty or its successor moves on.
  logic [NS+1:1] en;
  logic [NS:1]   v;

  always_comb begin
    en[NS+1] = !row_stall;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign point_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= point_valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Face conductivities on the left and right faces.
  cond_t cond_l;
  cond_t cond_r;

  dsrb_conduct #(.POW_TABLE_DEPTH(POW_TABLE_DEPTH)) u_cond_left (
    .clk (clk),
    .en  (en[COND_STAGES:1]),
    .a   (point.left_value),
    .b   (point.center_value),
    .k0  (conductivity_scale),
    .q   (conductivity_exponent),
    .res (cond_l)
  );

  dsrb_conduct #(.POW_TABLE_DEPTH(POW_TABLE_DEPTH)) u_cond_right (
    .clk (clk),
    .en  (en[COND_STAGES:1]),
    .a   (point.center_value),
    .b   (point.right_value),
    .k0  (conductivity_scale),
    .q   (conductivity_exponent),
    .res (cond_r)
  );

  // Side data pipeline and the product registers between its stages.
  meta_t meta_q [1:MS];
  meta_t meta_d [1:MS];

  logic signed [63:0] uu_q;
  logic signed [63:0] cube_raw_q;
  logic signed [63:0] sc_q;
  logic signed [63:0] cu_q;
  logic signed [63:0] res_raw_q;
  logic [55:0]        gl_raw_q;
  logic [55:0]        gr_raw_q;
  logic signed [63:0] frr_q;
  logic signed [63:0] fll_q;
  logic signed [63:0] dtsum_q;
  logic [61:0]        dtgl_q;
  logic [61:0]        dtgr_q;
  logic signed [63:0] diff_raw_q;
  logic [61:0]        dtsrc_q;
  row_word_t          row_q;
  row_word_t          row_next;

  logic [30:0] src_in;
  logic [31:0] ssrc_sum;
  logic [32:0] s_dr, s_dl, s_uu, s_cube, s_rad, s_cu, s_r1, s_res, s_sum, s_flux;
  logic [30:0] gl_s, gr_s, gl_eff;

  assign src_in   = (point.point_index[IB-1:0] <= source_end_index[IB-1:0]) ?
                    source_strength : '0;
  assign ssrc_sum = 32'(src_in) + 32'(radiation_constant);
  assign s_dr     = sat32(64'(point.right_value) - 64'(point.center_value));
  assign s_dl     = sat32(64'(point.center_value) - 64'(point.left_value));
  assign s_uu     = sat32(uu_q >>> 16);
  assign s_cube   = sat32(cube_raw_q >>> 16);
  assign s_rad    = sat32((sc_q >>> 16) <<< 2);
  assign s_cu     = sat32(cu_q >>> 16);
  assign s_r1     = sat32(64'($signed(s_cu[31:0])) - 64'sd65536);
  assign s_res    = sat32(res_raw_q >>> 16);
  assign gl_s     = (gl_raw_q[55:31] != '0) ? 31'h7FFF_FFFF : gl_raw_q[30:0];
  assign gr_s     = (gr_raw_q[55:31] != '0) ? 31'h7FFF_FFFF : gr_raw_q[30:0];
  // The mirror row has no left face.
  assign gl_eff   = meta_q[9].mirror ? '0 : gl_s;
  assign s_sum    = sat32($signed(64'(gl_eff)) + $signed(64'(gr_s)) + 64'(meta_q[9].rad));
  assign s_flux   = sat32((frr_q >>> 16) - (fll_q >>> 16));

  always_comb begin
    meta_d[1]        = '0;
    meta_d[1].row    = point.point_index;
    meta_d[1].last   = point.is_last_point;
    meta_d[1].mirror = (point.point_index[IB-1:0] == '0);
    meta_d[1].src_on = (point.point_index[IB-1:0] <= source_end_index[IB-1:0]);
    meta_d[1].u      = point.center_value;
    meta_d[1].d_r    = s_dr[31:0];
    meta_d[1].d_l    = s_dl[31:0];
    meta_d[1].ssrc   = ssrc_sum[31] ? 31'h7FFF_FFFF : ssrc_sum[30:0];
    meta_d[1].fl.dr  = s_dr[32];
    meta_d[1].fl.dl  = s_dl[32];
    meta_d[1].fl.ssrc = ssrc_sum[31];
    for (int k = 2; k <= MS; k++) begin
      meta_d[k] = meta_q[k-1];
    end
    meta_d[2].fl.uu   = s_uu[32];
    meta_d[3].fl.cube = s_cube[32];
    meta_d[4].rad     = s_rad[31:0];
    meta_d[4].r1      = s_r1[31:0];
    meta_d[4].fl.rad  = s_rad[32];
    meta_d[4].fl.cu   = s_cu[32];
    meta_d[4].fl.r1   = s_r1[32];
    meta_d[6].res     = s_res[31:0];
    meta_d[6].fl.res  = s_res[32];
    meta_d[9].fl.kl   = cond_l.sat;
    meta_d[9].fl.kr   = cond_r.sat;
    meta_d[10].gl     = gl_s;
    meta_d[10].gr     = gr_s;
    meta_d[10].sum    = s_sum[31:0];
    meta_d[10].flux   = s_flux[31:0];
    meta_d[10].fl.gl  = gl_raw_q[55:31] != '0;
    meta_d[10].fl.gr  = gr_raw_q[55:31] != '0;
    meta_d[10].fl.sum = s_sum[32];
    meta_d[10].fl.flux = s_flux[32];
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= MS; k++) begin
      if (en[k]) meta_q[k] <= meta_d[k];
    end
    if (en[1]) uu_q <= 64'(point.center_value) * 64'(point.center_value);
    if (en[2]) cube_raw_q <= 64'($signed(s_uu[31:0])) * 64'(meta_q[1].u);
    if (en[3]) begin
      sc_q <= 64'(sig_s) * 64'($signed(s_cube[31:0]));
      cu_q <= 64'($signed(s_cube[31:0])) * 64'(meta_q[2].u);
    end
    if (en[5]) res_raw_q <= 64'(sig_s) * 64'(meta_q[4].r1);
    if (en[9]) begin
      gl_raw_q <= 56'(cond_l.k) * 56'(inverse_spacing_squared);
      gr_raw_q <= 56'(cond_r.k) * 56'(inverse_spacing_squared);
      frr_q    <= 64'($signed({1'b0, cond_r.k})) * 64'(meta_q[8].d_r);
      fll_q    <= 64'($signed({1'b0, cond_l.k})) * 64'(meta_q[8].d_l);
    end
    if (en[11]) begin
      dtsum_q    <= 64'(dt_s) * 64'(meta_q[10].sum);
      dtgl_q     <= 62'(time_step) * 62'(meta_q[10].gl);
      dtgr_q     <= 62'(time_step) * 62'(meta_q[10].gr);
      diff_raw_q <= 64'(meta_q[10].flux) * 64'(spc_s);
      dtsrc_q    <= 62'(time_step) * 62'(meta_q[10].ssrc);
    end
    if (en[NS]) row_q <= row_next;
  end

  // Final stage: clamp the time step products and the residual, pick the row.
  logic [32:0] s_diag0, s_lo0, s_up0, s_rhs0, s_diff, s_fval, s_rhs1;
  logic        f_common;
  meta_t       mf;

  assign mf       = meta_q[MS];
  assign f_common = mf.fl.uu | mf.fl.cube | mf.fl.rad;
  assign s_diag0  = sat32(64'sd65536 + (dtsum_q >>> 16));
  assign s_lo0    = sat32(-$signed(64'(dtgl_q >> 16)));
  assign s_up0    = sat32(-$signed(64'(dtgr_q >> 16)));
  assign s_rhs0   = sat32(64'(mf.u) + $signed(64'(dtsrc_q >> 16)));
  assign s_diff   = sat32(diff_raw_q);
  assign s_fval   = sat32(64'(mf.res) - 64'($signed(s_diff[31:0])) -
                          $signed(64'(mf.src_on ? source_strength : 31'd0)));
  assign s_rhs1   = sat32(-64'($signed(s_fval[31:0])));

  always_comb begin
    row_next            = '0;
    row_next.row_number = mf.row;
    row_next.saturated  = f_common;
    if (mf.last) begin
      row_next.row_kind  = KIND_FIXED;
      row_next.diag_coef = ONE_Q;
      row_next.rhs_value = solve_mode ? 32'sd0 : ONE_Q;
    end else if (mf.mirror) begin
      row_next.row_kind = KIND_MIRROR;
      if (solve_mode) begin
        row_next.diag_coef  = ONE_Q;
        row_next.upper_coef = -ONE_Q;
      end else begin
        row_next.diag_coef  = s_diag0[31:0];
        row_next.upper_coef = s_up0[31:0];
        row_next.rhs_value  = s_rhs0[31:0];
        row_next.saturated  = f_common | mf.fl.kr | mf.fl.gr | mf.fl.sum | s_diag0[32] |
                              s_up0[32] | mf.fl.ssrc | s_rhs0[32];
      end
    end else begin
      row_next.row_kind = KIND_INTERIOR;
      if (solve_mode) begin
        row_next.lower_coef = -$signed({1'b0, mf.gl});
        row_next.upper_coef = -$signed({1'b0, mf.gr});
        row_next.diag_coef  = mf.sum;
        row_next.rhs_value  = s_rhs1[31:0];
        row_next.saturated  = f_common | mf.fl.kl | mf.fl.kr | mf.fl.gl | mf.fl.gr |
                              mf.fl.sum | mf.fl.dr | mf.fl.dl | mf.fl.flux | s_diff[32] |
                              mf.fl.cu | mf.fl.r1 | mf.fl.res | s_fval[32] | s_rhs1[32];
      end else begin
        row_next.lower_coef = s_lo0[31:0];
        row_next.diag_coef  = s_diag0[31:0];
        row_next.upper_coef = s_up0[31:0];
        row_next.rhs_value  = s_rhs0[31:0];
        row_next.saturated  = f_common | mf.fl.kl | mf.fl.kr | mf.fl.gl | mf.fl.gr |
                              mf.fl.sum | s_diag0[32] | s_lo0[32] | s_up0[32] |
                              mf.fl.ssrc | s_rhs0[32];
      end
    end
  end

  assign row_valid = v[NS];
  assign row       = row_q;

  // An empty output stage means every stage can move, so no back-pressure.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !v[NS] |-> !point_stall) else $error("point stalled with an empty output stage");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !row_valid) else $error("row word present after reset");

  a_fixed_row: assert property (@(posedge clk) disable iff (rst)
    row_valid && (row.row_kind == KIND_FIXED) |->
      (row.diag_coef == ONE_Q) && (row.lower_coef == 32'sd0) && (row.upper_coef == 32'sd0))
    else $error("fixed boundary row has wrong coefficients");

  a_mirror_row: assert property (@(posedge clk) disable iff (rst)
    row_valid && (row.row_kind == KIND_MIRROR) |-> (row.lower_coef == 32'sd0))
    else $error("mirror boundary row has a lower coefficient");

endmodule
